/* hw/rtl/mmcf_pkg.sv */
`default_nettype none

package mmcf_pkg;

   typedef struct packed {
      logic [1:0]  op;
      logic [23:0] short_msg;
      logic [7:0]  long_byte;
   } req_type;

   typedef struct packed {
      logic        read_valid;
      logic [7:0]  read_byte;
      logic [31:0] bytes_pushed;
      logic        overflowed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_STORE,
      ST_POST,
      ST_READ,
      ST_DONE
   } state_type;

   localparam logic [1:0] OP_SHORT = 2'd0;
   localparam logic [1:0] OP_SYSEX = 2'd1;
   localparam logic [1:0] OP_POP   = 2'd2;

   localparam logic [7:0] STATUS_MIN    = 8'h80;
   localparam logic [7:0] REALTIME_MIN  = 8'hF8;
   localparam logic [7:0] HI_MASK       = 8'hF0;
   localparam logic [7:0] PROG_CHANGE   = 8'hC0;
   localparam logic [7:0] CHAN_PRESSURE = 8'hD0;
   localparam logic [7:0] TIME_CODE     = 8'hF1;
   localparam logic [7:0] SONG_POS      = 8'hF2;
   localparam logic [7:0] SONG_SELECT   = 8'hF3;
   localparam logic [7:0] SINGLE_MIN    = 8'hF4;
   localparam logic [7:0] SYSEX_START   = 8'hF0;
   localparam logic [7:0] SYSEX_END     = 8'hF7;

   localparam logic [1:0] LEN_ONE   = 2'd1;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

endpackage

`default_nettype wire

/* hw/rtl/midi_message_commit_fifo_unit.sv */
`default_nettype none

// MIDI receive ring with whole-message commit. Each word on req_ is a short
// message, one SysEx byte or a pop; each returns exactly one word on rsp_.
// A small sequencer drives every ring byte through one RAM, one byte per
// cycle, plus a step for each commit, and req_stall is high while an item
// is in progress. A new word is taken while the previous result still waits
// on rsp_; that next item then holds in its done step until the waiting
// result leaves. Ring contents need no clearing after reset; the ring holds
// at most RING_DEPTH-1 bytes.
module midi_message_commit_fifo_unit #(
   parameter int RING_DEPTH = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mmcf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mmcf_pkg::rsp_type     rsp_data
);

   localparam int              ADDR_W = $clog2(RING_DEPTH);
   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(RING_DEPTH - 1);

   mmcf_pkg::state_type state_ff, state_in;
   logic [2:0][7:0]     bytes_ff, bytes_in;
   logic [1:0]          left_ff, left_in;
   logic                pre_ff, pre_in;
   logic                post_ff, post_in;
   logic                sysex_ff, sysex_in;
   logic                ovf_ff, ovf_in;
   logic [ADDR_W-1:0]   pend_ff, pend_in;
   logic [ADDR_W-1:0]   commit_ff, commit_in;
   logic [ADDR_W-1:0]   rdp_ff, rdp_in;
   logic [31:0]         count_ff, count_in;
   logic                res_valid_ff, res_valid_in;
   logic [7:0]          res_byte_ff, res_byte_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mmcf_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [7:0]        ram_rd_data;
   logic [ADDR_W-1:0] pend_nxt;
   logic [ADDR_W-1:0] rdp_nxt;
   logic [7:0]        st;
   logic [7:0]        lb;
   logic [1:0]        len;

   mmcf_ram #(
      .WIDTH(8),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(pend_ff),
      .wr_data(bytes_ff[0]),
      .rd_en  (ram_rd_en),
      .rd_addr(rdp_ff),
      .rd_data(ram_rd_data)
   );

   assign pend_nxt  = (pend_ff == LAST) ? '0 : pend_ff + ADDR_W'(1);
   assign rdp_nxt   = (rdp_ff == LAST) ? '0 : rdp_ff + ADDR_W'(1);
   assign st        = req_data.short_msg[7:0];
   assign lb        = req_data.long_byte;
   assign req_stall = (state_ff != mmcf_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      len = mmcf_pkg::LEN_THREE;
      if ((st & mmcf_pkg::HI_MASK) == mmcf_pkg::PROG_CHANGE ||
          (st & mmcf_pkg::HI_MASK) == mmcf_pkg::CHAN_PRESSURE) begin
         len = mmcf_pkg::LEN_TWO;
      end
      if (st == mmcf_pkg::TIME_CODE || st == mmcf_pkg::SONG_SELECT) begin
         len = mmcf_pkg::LEN_TWO;
      end else if (st == mmcf_pkg::SONG_POS) begin
         len = mmcf_pkg::LEN_THREE;
      end else if (st >= mmcf_pkg::SINGLE_MIN) begin
         len = mmcf_pkg::LEN_ONE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      bytes_in     = bytes_ff;
      left_in      = left_ff;
      pre_in       = pre_ff;
      post_in      = post_ff;
      sysex_in     = sysex_ff;
      ovf_in       = ovf_ff;
      pend_in      = pend_ff;
      commit_in    = commit_ff;
      rdp_in       = rdp_ff;
      count_in     = count_ff;
      res_valid_in = res_valid_ff;
      res_byte_in  = res_byte_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         mmcf_pkg::ST_IDLE: begin
            if (req_valid) begin
               res_valid_in = 1'b0;
               res_byte_in  = '0;
               pre_in       = 1'b0;
               post_in      = 1'b0;
               left_in      = '0;
               bytes_in[0]  = st;
               bytes_in[1]  = req_data.short_msg[15:8];
               bytes_in[2]  = req_data.short_msg[23:16];
               case (req_data.op)
                  mmcf_pkg::OP_SHORT: begin
                     if (st >= mmcf_pkg::STATUS_MIN) begin
                        if (st >= mmcf_pkg::REALTIME_MIN) begin
                           left_in = mmcf_pkg::LEN_ONE;
                           post_in = !sysex_ff;
                        end else begin
                           pre_in   = sysex_ff;
                           sysex_in = 1'b0;
                           post_in  = 1'b1;
                           left_in  = len;
                        end
                     end
                  end
                  mmcf_pkg::OP_SYSEX: begin
                     bytes_in[0] = lb;
                     if (lb == mmcf_pkg::SYSEX_START) begin
                        pre_in   = sysex_ff;
                        sysex_in = 1'b1;
                     end
                     if (lb == mmcf_pkg::SYSEX_START || sysex_ff) begin
                        left_in = mmcf_pkg::LEN_ONE;
                        if (lb == mmcf_pkg::SYSEX_END) begin
                           post_in  = 1'b1;
                           sysex_in = 1'b0;
                        end
                     end
                  end
                  mmcf_pkg::OP_POP: begin
                     if (rdp_ff != commit_ff) begin
                        ram_rd_en    = 1'b1;
                        rdp_in       = rdp_nxt;
                        res_valid_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (ram_rd_en) begin
                  state_in = mmcf_pkg::ST_READ;
               end else if (pre_in) begin
                  state_in = mmcf_pkg::ST_PRE;
               end else if (left_in != '0) begin
                  state_in = mmcf_pkg::ST_STORE;
               end else if (post_in) begin
                  state_in = mmcf_pkg::ST_POST;
               end else begin
                  state_in = mmcf_pkg::ST_DONE;
               end
            end
         end
         mmcf_pkg::ST_PRE, mmcf_pkg::ST_POST: begin
            if (ovf_ff) begin
               pend_in = commit_ff;
               ovf_in  = 1'b0;
            end else begin
               commit_in = pend_ff;
            end
            if (state_ff == mmcf_pkg::ST_POST) begin
               state_in = mmcf_pkg::ST_DONE;
            end else if (left_ff != '0) begin
               state_in = mmcf_pkg::ST_STORE;
            end else if (post_ff) begin
               state_in = mmcf_pkg::ST_POST;
            end else begin
               state_in = mmcf_pkg::ST_DONE;
            end
         end
         mmcf_pkg::ST_STORE: begin
            if (!ovf_ff) begin
               if (pend_nxt == rdp_ff) begin
                  ovf_in = 1'b1;
               end else begin
                  ram_wr_en = 1'b1;
                  pend_in   = pend_nxt;
                  count_in  = count_ff + 32'd1;
               end
            end
            bytes_in[0] = bytes_ff[1];
            bytes_in[1] = bytes_ff[2];
            left_in     = left_ff - 2'd1;
            if (left_ff == mmcf_pkg::LEN_ONE) begin
               state_in = post_ff ? mmcf_pkg::ST_POST : mmcf_pkg::ST_DONE;
            end
         end
         mmcf_pkg::ST_READ: begin
            res_byte_in = ram_rd_data;
            state_in    = mmcf_pkg::ST_DONE;
         end
         mmcf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.read_valid    = res_valid_ff;
               rsp_data_in.read_byte     = res_byte_ff;
               rsp_data_in.bytes_pushed  = count_ff;
               rsp_data_in.overflowed    = ovf_ff;
               state_in                  = mmcf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mmcf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmcf_pkg::ST_IDLE;
         left_ff      <= '0;
         pre_ff       <= 1'b0;
         post_ff      <= 1'b0;
         sysex_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         pend_ff      <= '0;
         commit_ff    <= '0;
         rdp_ff       <= '0;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         pre_ff       <= pre_in;
         post_ff      <= post_in;
         sysex_ff     <= sysex_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         commit_ff    <= commit_in;
         rdp_ff       <= rdp_in;
         count_ff     <= count_in;
         res_valid_ff <= res_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff    <= bytes_in;
      res_byte_ff <= res_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + 32'd1))
      else $error("push count moved by more than one");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mmcf_pkg::ST_DONE))
      else $error("result raised outside of done step");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != mmcf_pkg::ST_IDLE))
      else $error("accepted word did not start the sequencer");

   a_ovf_holds_pend: assert property (@(posedge clock) disable iff (reset)
      (ovf_ff && state_ff == mmcf_pkg::ST_STORE) |=> $stable(pend_ff))
      else $error("pending pointer moved during overflow");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> (rdp_ff != commit_ff))
      else $error("pop read past the commit pointer");
`endif

endmodule

`default_nettype wire

/* hw/rtl/mmcf_ram.sv */
`default_nettype none

module mmcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sim/tb_midi_message_commit_fifo_unit.sv */
`timescale 1ns / 1ps

module tb_midi_message_commit_fifo_unit;

   localparam int RING_SIZE = 256;
   localparam int HOLD_CYCLES = 300;
   localparam int STUCK_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 20;
   localparam int TARGET_WORDS = 650;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [7:0] NOTE_ON = 8'h90;
   localparam logic [7:0] SYSTEM_RESET = 8'hFF;

   class commit_ring_predictor;
      logic [7:0]  ring [RING_SIZE];
      bit [7:0]    pend_ptr;
      bit [7:0]    commit_ptr;
      bit [7:0]    read_ptr;
      bit          sysex_open;
      bit          overflow;
      bit [31:0]   push_count;
      mmcf_pkg::rsp_type awaited_rsp [$];
      int          mismatches;
      int          words_checked;
      int          bytes_popped;
      int          overflow_drops;

      function bit [7:0] next_slot(bit [7:0] p);
         return (p == 8'(RING_SIZE - 1)) ? 8'd0 : p + 8'd1;
      endfunction

      function void store(logic [7:0] b);
         bit [7:0] nxt;
         if (overflow) return;
         nxt = next_slot(pend_ptr);
         if (nxt == read_ptr) begin
            overflow = 1'b1;
            overflow_drops++;
            return;
         end
         ring[pend_ptr] = b;
         pend_ptr = nxt;
         push_count++;
      endfunction

      function void commit();
         if (overflow) begin
            pend_ptr = commit_ptr;
            overflow = 1'b0;
         end else begin
            commit_ptr = pend_ptr;
         end
      endfunction

      function void short_message(logic [23:0] msg);
         logic [7:0] status;
         logic [1:0] len;
         status = msg[7:0];
         if (status < mmcf_pkg::STATUS_MIN) return;
         if (status >= mmcf_pkg::REALTIME_MIN) begin
            store(status);
            if (!sysex_open) commit();
            return;
         end
         if (sysex_open) begin
            sysex_open = 1'b0;
            commit();
         end
         len = mmcf_pkg::LEN_THREE;
         if ((status & mmcf_pkg::HI_MASK) == mmcf_pkg::PROG_CHANGE ||
             (status & mmcf_pkg::HI_MASK) == mmcf_pkg::CHAN_PRESSURE)
            len = mmcf_pkg::LEN_TWO;
         if (status == mmcf_pkg::TIME_CODE || status == mmcf_pkg::SONG_SELECT)
            len = mmcf_pkg::LEN_TWO;
         else if (status == mmcf_pkg::SONG_POS) len = mmcf_pkg::LEN_THREE;
         else if (status >= mmcf_pkg::SINGLE_MIN) len = mmcf_pkg::LEN_ONE;
         store(status);
         if (len > mmcf_pkg::LEN_ONE) store(msg[15:8]);
         if (len > mmcf_pkg::LEN_TWO) store(msg[23:16]);
         commit();
      endfunction

      function void sysex_byte(logic [7:0] b);
         if (b == mmcf_pkg::SYSEX_START) begin
            if (sysex_open) commit();
            sysex_open = 1'b1;
         end
         if (!sysex_open) return;
         store(b);
         if (b == mmcf_pkg::SYSEX_END) begin
            sysex_open = 1'b0;
            commit();
         end
      endfunction

      function void note_request(mmcf_pkg::req_type w);
         mmcf_pkg::rsp_type want;
         want = '0;
         case (w.op)
            mmcf_pkg::OP_SHORT: short_message(w.short_msg);
            mmcf_pkg::OP_SYSEX: sysex_byte(w.long_byte);
            mmcf_pkg::OP_POP: begin
               if (read_ptr != commit_ptr) begin
                  want.read_valid = 1'b1;
                  want.read_byte = ring[read_ptr];
                  read_ptr = next_slot(read_ptr);
                  bytes_popped++;
               end
            end
            default: ;
         endcase
         want.bytes_pushed = push_count;
         want.overflowed = overflow;
         awaited_rsp.push_back(want);
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
      endfunction

      function void check_response(mmcf_pkg::rsp_type got);
         mmcf_pkg::rsp_type want;
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("rsp word with no request waiting: %h", got);
            return;
         end
         want = awaited_rsp.pop_front();
         words_checked++;
         if (got.read_valid !== want.read_valid)
            report("read_valid", 32'(want.read_valid), 32'(got.read_valid));
         if (got.read_byte !== want.read_byte)
            report("read_byte", 32'(want.read_byte), 32'(got.read_byte));
         if (got.bytes_pushed !== want.bytes_pushed)
            report("bytes_pushed", want.bytes_pushed, got.bytes_pushed);
         if (got.overflowed !== want.overflowed)
            report("overflowed", 32'(want.overflowed), 32'(got.overflowed));
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   mmcf_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   mmcf_pkg::rsp_type rsp_data;

   commit_ring_predictor ring_pred;
   int words_sent;
   int stuck_cycles;
   bit no_gaps;
   bit hold_request;
   bit run_done;

   midi_message_commit_fifo_unit #(
      .RING_DEPTH(RING_SIZE)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(15, 60);
      return $urandom_range(1, 4);
   endfunction

   function automatic mmcf_pkg::req_type random_word();
      mmcf_pkg::req_type w;
      w.op = 2'($urandom);
      w.short_msg = 24'($urandom);
      w.long_byte = 8'($urandom);
      return w;
   endfunction

   task automatic send_word(input mmcf_pkg::req_type w);
      int gap;
      if (!no_gaps && $urandom_range(0, 2) == 0) begin
         gap = gap_length();
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_op(input logic [1:0] op);
      mmcf_pkg::req_type w;
      w = random_word();
      w.op = op;
      send_word(w);
   endtask

   task automatic send_short(input logic [23:0] msg);
      mmcf_pkg::req_type w;
      w = random_word();
      w.op = mmcf_pkg::OP_SHORT;
      w.short_msg = msg;
      send_word(w);
   endtask

   task automatic send_sysex(input logic [7:0] b);
      mmcf_pkg::req_type w;
      w = random_word();
      w.op = mmcf_pkg::OP_SYSEX;
      w.long_byte = b;
      send_word(w);
   endtask

   function automatic logic [7:0] random_status();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return {4'($urandom_range(8, 14)), 4'($urandom)};
      if (r < 75)
         return 8'($urandom_range(mmcf_pkg::SYSEX_START, mmcf_pkg::SYSEX_END));
      if (r < 92) return 8'($urandom_range(mmcf_pkg::REALTIME_MIN, SYSTEM_RESET));
      return 8'($urandom_range(0, mmcf_pkg::STATUS_MIN - 1));
   endfunction

   task automatic send_sysex_run();
      int n;
      int r;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      send_sysex(mmcf_pkg::SYSEX_START);
      repeat (n) begin
         r = $urandom_range(0, 19);
         if (r == 0)
            send_short({16'($urandom),
                        8'($urandom_range(mmcf_pkg::REALTIME_MIN, SYSTEM_RESET))});
         else if (r == 1) send_sysex(8'($urandom));
         else send_sysex(8'($urandom_range(0, 127)));
      end
      r = $urandom_range(0, 99);
      if (r < 70) send_sysex(mmcf_pkg::SYSEX_END);
      else if (r < 85) send_short({16'($urandom), random_status()});
   endtask

   task automatic send_random(input int pop_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < pop_pct) begin
         send_op(mmcf_pkg::OP_POP);
         return;
      end
      r = $urandom_range(0, 99);
      if (r < 60) send_short({16'($urandom), random_status()});
      else if (r < 85) send_sysex_run();
      else if (r < 92) send_sysex(8'($urandom));
      else send_op(OP_UNUSED);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) ring_pred.note_request(req_data);
         if (rsp_valid && !rsp_stall) ring_pred.check_response(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || run_done)
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
   end

   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!no_gaps && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat (gap_length()) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   initial begin
      stuck_cycles = 0;
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
      $display("tb_midi_message_commit_fifo_unit: FAIL");
      $finish;
   end

   initial begin
      int phase;
      int kind;
      int len;
      int pop_pct;
      ring_pred = new;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      words_sent = 0;
      no_gaps = 1'b0;
      hold_request = 1'b0;
      run_done = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_op(mmcf_pkg::OP_POP);
      send_op(OP_UNUSED);
      send_short(24'h000000);
      send_short({16'hFFFF, 8'h7F});
      send_short({8'h7F, 8'h40, NOTE_ON});
      send_short({16'h0000, mmcf_pkg::STATUS_MIN});
      send_short({8'hAA, 8'h11, mmcf_pkg::PROG_CHANGE | 8'h05});
      send_short({8'h55, 8'h22, mmcf_pkg::CHAN_PRESSURE | 8'h0F});
      send_short({8'h33, 8'h44, mmcf_pkg::TIME_CODE});
      send_short({8'h66, 8'h77, mmcf_pkg::SONG_SELECT});
      send_short({8'h12, 8'h34, mmcf_pkg::SONG_POS});
      send_short({8'h56, 8'h78, mmcf_pkg::SINGLE_MIN});
      send_short({8'h9A, 8'hBC, mmcf_pkg::SYSEX_END});
      send_short({8'hDE, 8'hF0, mmcf_pkg::SYSEX_START});
      send_short(24'hFFFFFF);
      send_short({16'h1357, mmcf_pkg::REALTIME_MIN});
      send_sysex(8'h42);
      send_sysex(mmcf_pkg::SYSEX_START);
      send_sysex(8'h11);
      send_short({16'h2468, mmcf_pkg::REALTIME_MIN});
      send_sysex(mmcf_pkg::SYSEX_START);
      send_sysex(8'h22);
      send_short({8'h01, 8'h3C, NOTE_ON});
      send_sysex(mmcf_pkg::SYSEX_START);
      send_sysex(8'h33);
      send_sysex(mmcf_pkg::SYSEX_END);

      phase = 0;
      while (words_sent < TARGET_WORDS) begin
         kind = $urandom_range(0, 2);
         if (kind == 0) begin
            len = $urandom_range(100, 160);
            pop_pct = 5;
         end else if (kind == 1) begin
            len = $urandom_range(30, 90);
            pop_pct = 75;
         end else begin
            len = $urandom_range(20, 60);
            pop_pct = 35;
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         if (phase == 0 || phase == 3) begin
            hold_request = 1'b1;
            no_gaps = 1'b1;
         end
         repeat (len) begin
            if (words_sent < TARGET_WORDS) send_random(pop_pct);
         end
         phase++;
      end
      req_valid <= 1'b0;
      no_gaps = 1'b0;

      while (ring_pred.awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      run_done = 1'b1;
      $display("checked %0d rsp words over %0d phases: %0d bytes popped, %0d bytes pushed",
               ring_pred.words_checked, phase, ring_pred.bytes_popped,
               ring_pred.push_count);
      $display("ring-full drops %0d, mismatches %0d",
               ring_pred.overflow_drops, ring_pred.mismatches);
      if (ring_pred.mismatches == 0 && ring_pred.awaited_rsp.size() == 0) begin
         $display("tb_midi_message_commit_fifo_unit: PASS");
      end else begin
         $display("tb_midi_message_commit_fifo_unit: FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/mmcf_pkg.sv
hw/rtl/mmcf_ram.sv
hw/rtl/midi_message_commit_fifo_unit.sv
sim/tb_midi_message_commit_fifo_unit.sv
